@@ rtl/vga_scanline_address_generator_core_assert.svh @@
// Assertion macros for the scanline address generator core.
`ifndef VGA_SCANLINE_ADDRESS_GENERATOR_CORE_ASSERT_SVH
`define VGA_SCANLINE_ADDRESS_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define VSAG_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vsag: implication check failed");

// Next-cycle implication, disabled in reset.
`define VSAG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vsag: next-cycle check failed");

`endif

@@ rtl/vsag_pkg.sv @@
// Shared types and constants for the scanline address generator.
`default_nettype none

package vsag_pkg;

   localparam int ADDR_BITS_DEFAULT = 24;
   localparam int MAX_LINES_DEFAULT = 2048;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_ADDRESS  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_PITCH      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPLIT_LINE     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_SCAN_LINE  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCAN_DOUBLING  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CGA_SHIFT_MODE = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE_CONTROL   = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT   = 3'd7;

   // reset values
   localparam logic [15:0] SPLIT_LINE_RESET   = 16'hffff;
   localparam logic [7:0]  MODE_CONTROL_RESET = 8'h03;
   localparam logic [11:0] FRAME_HEIGHT_RESET = 12'd480;

   typedef struct packed {
      logic [15:0] start_address;
      logic [15:0] row_pitch;
      logic [15:0] split_line;
      logic [4:0]  max_scan_line;
      logic        scan_doubling;
      logic        cga_shift_mode;
      logic [7:0]  mode_control;
      logic [11:0] frame_height;
   } cfg_type;

   typedef struct packed {
      logic frame_start;
      logic line_dirty;
   } req_type;

   typedef struct packed {
      logic [23:0] line_address;
      logic [10:0] line_number;
      logic        draw_line;
      logic        flush_valid;
      logic [10:0] flush_first;
      logic [11:0] flush_count;
      logic        last_line;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/vsag_line_calc.sv @@
// Per-line step: address, interleave, repeat counting, split and flush runs.
`default_nettype none

module vsag_line_calc #(
   parameter int ADDR_BITS = vsag_pkg::ADDR_BITS_DEFAULT,
   parameter int MAX_LINES = vsag_pkg::MAX_LINES_DEFAULT
) (
   input  vsag_pkg::cfg_type              cfg,
   input  vsag_pkg::req_type              req,
   input  logic [ADDR_BITS-1:0]           row_base,
   input  logic [11:0]                    row_counter,
   input  logic [5:0]                     repeat_left,
   input  logic [$clog2(MAX_LINES)-1:0]   line_counter,
   input  logic [$clog2(MAX_LINES)-1:0]   run_start,
   input  logic                           run_open,
   output logic [ADDR_BITS-1:0]           row_base_next,
   output logic [11:0]                    row_counter_next,
   output logic [5:0]                     repeat_left_next,
   output logic [$clog2(MAX_LINES)-1:0]   line_counter_next,
   output logic [$clog2(MAX_LINES)-1:0]   run_start_next,
   output logic                           run_open_next,
   output vsag_pkg::rsp_type              rsp
);

   localparam int LINE_BITS = $clog2(MAX_LINES);
   localparam logic [LINE_BITS-1:0] LINE_TOP = LINE_BITS'(MAX_LINES - 1);

   logic [5:0]           repeat_load;
   logic [17:0]          start_bytes;
   logic [ADDR_BITS-1:0] base_e;
   logic [11:0]          rowc_e;
   logic [5:0]           rep_e;
   logic [LINE_BITS-1:0] y;
   logic [LINE_BITS-1:0] rs_e;
   logic                 open_e;
   logic [ADDR_BITS-1:0] addr;
   logic                 last;
   logic [LINE_BITS-1:0] rs_cur;
   logic [1:0]           row_mask;

   // repeat count per row: (msl + 1) << ds, minus one; CGA mode uses ds alone
   always_comb begin
      if (cfg.cga_shift_mode) begin
         repeat_load = {5'd0, cfg.scan_doubling};
      end else if (cfg.scan_doubling) begin
         repeat_load = {cfg.max_scan_line, 1'b1};
      end else begin
         repeat_load = {1'b0, cfg.max_scan_line};
      end
   end

   // frame start reloads everything before the line is used
   assign start_bytes = {cfg.start_address, 2'b00};
   assign base_e = req.frame_start ? ADDR_BITS'(start_bytes) : row_base;
   assign rowc_e = req.frame_start ? 12'd0 : row_counter;
   assign rep_e  = req.frame_start ? repeat_load : repeat_left;
   assign y      = req.frame_start ? '0 : line_counter;
   assign rs_e   = req.frame_start ? '0 : run_start;
   assign open_e = req.frame_start ? 1'b0 : run_open;

   // CGA odd-row interleave, then the 0x8000 interleave
   always_comb begin
      addr = base_e;
      if (!cfg.mode_control[0]) begin
         if (cfg.mode_control[6]) begin
            addr[15] = rowc_e[0];
         end else begin
            addr[14] = rowc_e[0];
         end
      end
      if (!cfg.mode_control[1]) begin
         addr[15] = rowc_e[1];
      end
   end

   assign last   = (13'(y) + 13'd1) == {1'b0, cfg.frame_height};
   assign rs_cur = open_e ? rs_e : y;

   // result fields and flush runs
   always_comb begin
      rsp.line_address = 24'(addr);
      rsp.line_number  = 11'(y);
      rsp.draw_line    = req.line_dirty;
      rsp.last_line    = last;
      rsp.flush_valid  = 1'b0;
      rsp.flush_first  = '0;
      rsp.flush_count  = '0;
      run_open_next    = open_e;
      run_start_next   = rs_cur;
      if (req.line_dirty) begin
         run_open_next = 1'b1;
         if (last) begin
            rsp.flush_valid = 1'b1;
            rsp.flush_first = 11'(rs_cur);
            rsp.flush_count = 12'(y) + 12'd1 - 12'(rs_cur);
            run_open_next   = 1'b0;
         end
      end else if (open_e) begin
         rsp.flush_valid = 1'b1;
         rsp.flush_first = 11'(rs_e);
         rsp.flush_count = 12'(y) - 12'(rs_e);
         run_open_next   = 1'b0;
      end
   end

   // row advance; interleave bits that are on hold the base for extra rows
   assign row_mask = ~cfg.mode_control[1:0];

   always_comb begin
      row_base_next    = base_e;
      row_counter_next = rowc_e;
      repeat_left_next = rep_e - 6'd1;
      if (rep_e == 6'd0) begin
         if ((rowc_e[1:0] & row_mask) == row_mask) begin
            row_base_next = base_e + ADDR_BITS'(cfg.row_pitch);
         end
         row_counter_next = rowc_e + 12'd1;
         repeat_left_next = repeat_load;
      end
      if (16'(y) == cfg.split_line) begin
         row_base_next = '0;
      end
   end

   assign line_counter_next = (y == LINE_TOP) ? '0 : y + LINE_BITS'(1);

endmodule

`default_nettype wire

@@ rtl/vga_scanline_address_generator_core.sv @@
// Top level of the VGA scanline address generator.
`default_nettype none

// One item per displayed scanline goes in (frame-start mark, dirty bit) and
// one result item comes out: the line's video memory byte address, its line
// number, the draw flag, an optional flush rectangle (first line and line
// count of a finished run of redrawn lines) and a last-line flag. The row
// base, character-row and scan-repeat counters live here and are updated by
// a single combinational line step between the input register and the
// result register. Throughput is one item per clock unless the result stalls;
// an item passes the input register, then the result register. A stalled
// result only holds the pipe once both registers are full. The user writes
// configuration registers through the csr_ port only while no item is in
// flight (not enforced by the block); writes take effect on the next item.
// Addresses wrap modulo 2^ADDR_BITS and the line counter wraps at MAX_LINES.

`include "vga_scanline_address_generator_core_assert.svh"

module vga_scanline_address_generator_core #(
   parameter int ADDR_BITS = vsag_pkg::ADDR_BITS_DEFAULT,
   parameter int MAX_LINES = vsag_pkg::MAX_LINES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_write_enable,
   input  logic [vsag_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [vsag_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   // line items in
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  vsag_pkg::req_type                     req_payload,
   // result items out
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output vsag_pkg::rsp_type                     rsp_payload
);

   localparam int LINE_BITS = $clog2(MAX_LINES);

   // configuration registers
   vsag_pkg::cfg_type cfg_ff;
   vsag_pkg::cfg_type cfg_in;

   // line state
   logic [ADDR_BITS-1:0] row_base_ff,     row_base_in;
   logic [11:0]          row_counter_ff,  row_counter_in;
   logic [5:0]           repeat_left_ff,  repeat_left_in;
   logic [LINE_BITS-1:0] line_counter_ff, line_counter_in;
   logic [LINE_BITS-1:0] run_start_ff,    run_start_in;
   logic                 run_open_ff,     run_open_in;

   // input register and result register
   logic              s1_valid_ff,  s1_valid_in;
   vsag_pkg::req_type s1_req_ff,    s1_req_in;
   logic              rsp_valid_ff, rsp_valid_in;
   vsag_pkg::rsp_type rsp_ff,       rsp_in;

   // step outputs
   logic [ADDR_BITS-1:0] row_base_step;
   logic [11:0]          row_counter_step;
   logic [5:0]           repeat_left_step;
   logic [LINE_BITS-1:0] line_counter_step;
   logic [LINE_BITS-1:0] run_start_step;
   logic                 run_open_step;
   vsag_pkg::rsp_type    rsp_step;

   logic advance;   // result register can take a new item
   logic step;      // input register item moves through the line step
   logic req_take;

   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign step     = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;

   vsag_line_calc #(
      .ADDR_BITS (ADDR_BITS),
      .MAX_LINES (MAX_LINES)
   ) u_line_calc (
      .cfg               (cfg_ff),
      .req               (s1_req_ff),
      .row_base          (row_base_ff),
      .row_counter       (row_counter_ff),
      .repeat_left       (repeat_left_ff),
      .line_counter      (line_counter_ff),
      .run_start         (run_start_ff),
      .run_open          (run_open_ff),
      .row_base_next     (row_base_step),
      .row_counter_next  (row_counter_step),
      .repeat_left_next  (repeat_left_step),
      .line_counter_next (line_counter_step),
      .run_start_next    (run_start_step),
      .run_open_next     (run_open_step),
      .rsp               (rsp_step)
   );

   // config writes, masked to register width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            vsag_pkg::CSR_START_ADDRESS:  cfg_in.start_address  = csr_write_data;
            vsag_pkg::CSR_ROW_PITCH:      cfg_in.row_pitch      = csr_write_data;
            vsag_pkg::CSR_SPLIT_LINE:     cfg_in.split_line     = csr_write_data;
            vsag_pkg::CSR_MAX_SCAN_LINE:  cfg_in.max_scan_line  = csr_write_data[4:0];
            vsag_pkg::CSR_SCAN_DOUBLING:  cfg_in.scan_doubling  = csr_write_data[0];
            vsag_pkg::CSR_CGA_SHIFT_MODE: cfg_in.cga_shift_mode = csr_write_data[0];
            vsag_pkg::CSR_MODE_CONTROL:   cfg_in.mode_control   = csr_write_data[7:0];
            vsag_pkg::CSR_FRAME_HEIGHT:   cfg_in.frame_height   = csr_write_data[11:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // state moves only when an item passes the line step
   always_comb begin
      row_base_in     = row_base_ff;
      row_counter_in  = row_counter_ff;
      repeat_left_in  = repeat_left_ff;
      line_counter_in = line_counter_ff;
      run_start_in    = run_start_ff;
      run_open_in     = run_open_ff;
      rsp_in          = rsp_ff;
      if (step) begin
         row_base_in     = row_base_step;
         row_counter_in  = row_counter_step;
         repeat_left_in  = repeat_left_step;
         line_counter_in = line_counter_step;
         run_start_in    = run_start_step;
         run_open_in     = run_open_step;
         rsp_in          = rsp_step;
      end
   end

   // pipe control
   always_comb begin
      s1_req_in = req_take ? req_payload : s1_req_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_address  <= '0;
         cfg_ff.row_pitch      <= '0;
         cfg_ff.split_line     <= vsag_pkg::SPLIT_LINE_RESET;
         cfg_ff.max_scan_line  <= '0;
         cfg_ff.scan_doubling  <= 1'b0;
         cfg_ff.cga_shift_mode <= 1'b0;
         cfg_ff.mode_control   <= vsag_pkg::MODE_CONTROL_RESET;
         cfg_ff.frame_height   <= vsag_pkg::FRAME_HEIGHT_RESET;
         row_base_ff     <= '0;
         row_counter_ff  <= '0;
         repeat_left_ff  <= '0;
         line_counter_ff <= '0;
         run_start_ff    <= '0;
         run_open_ff     <= 1'b0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         cfg_ff          <= cfg_in;
         row_base_ff     <= row_base_in;
         row_counter_ff  <= row_counter_in;
         repeat_left_ff  <= repeat_left_in;
         line_counter_ff <= line_counter_in;
         run_start_ff    <= run_start_in;
         run_open_ff     <= run_open_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // an item that leaves the input register always lands in the result register
   `VSAG_ASSERT_NEXT(a_step_fills_rsp, clock, reset, step, rsp_valid_ff)

   // no flush means empty rectangle fields
   `VSAG_ASSERT_IMPLIES(a_flush_fields_clear, clock, reset,
      rsp_valid_ff && !rsp_ff.flush_valid,
      rsp_ff.flush_first == 11'd0 && rsp_ff.flush_count == 12'd0)

   // a redrawn last line always closes the run
   `VSAG_ASSERT_NEXT(a_last_closes_run, clock, reset,
      step && rsp_step.last_line && rsp_step.draw_line, !run_open_ff)

endmodule

`default_nettype wire
